@@ src/toeq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared codes, command and status types for the time-ordered event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int TIME_W    = 32;
  localparam int PAYLOAD_W = 32;
  localparam int ENTRY_W   = TIME_W + PAYLOAD_W;

  // operation codes (in_tuser)
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_PEEK    = 2'd2;
  localparam logic [1:0] KIND_DELETE  = 2'd3;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic signed [TIME_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_TAIL,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic {
    ASEL_PTR,
    ASEL_PTR_P1
  } addr_sel_t;

  typedef enum logic {
    WSEL_NEW,
    WSEL_RDATA
  } wdata_sel_t;

  typedef struct packed {
    logic       load;
    logic       set_status;
    logic [1:0] status;
    logic       set_peek_empty;
    logic       cap_res;
    logic       cap_peek;
    ptr_op_t    ptr_op;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wd_sel;
    cnt_op_t    cnt_op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       extreme;
    logic       full;
    logic       empty;
    logic       ptr_zero;
    logic       ptr_last;
    logic       rd_lt;
    logic       rd_eq;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ src/time_ordered_event_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_ordered_event_queue_unit
// Sorted event queue (insert, dequeue, peek, delete by time) over one RAM.
// ----------------------------------------------------------------------------
// Insert walks down from the tail, moving later-or-equal entries up; dequeue and
// delete scan from the head, then pull the entries behind the removed one down.
// Each entry visited takes a read state and then an evaluate state. A refused
// insert or a non-insert item on an empty queue goes straight to the result.
// One item in flight: the next is taken once the result is in the output
// register. Reset empties the queue (count only); the RAM is not cleared.
module time_ordered_event_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] event_time, [63:32] event_payload
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] result_time, [63:32] result_payload
  output logic [1:0]       out_tuser   // [1:0] status
);

  toeq_pkg::cmd_t  cmd;
  toeq_pkg::stat_t st;

  toeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  toeq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // a new entry is only ever added to a queue with room
  a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == toeq_pkg::CNT_INC) |-> !st.full)
    else $error("entry count grows past capacity");

  // removal only from a non-empty queue
  a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == toeq_pkg::CNT_DEC) |-> !st.empty)
    else $error("entry count underflow");

  // the output register is never overwritten while its item is still held
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result overwritten before it was taken");

  // a result never appears in the cycle right after an item is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule
`default_nettype wire

@@ src/toeq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module toeq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/toeq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toeq_dp
// Queue datapath: item registers, scan pointer, entry count, sorted entry
// RAM, result registers and the output register.
// ----------------------------------------------------------------------------
module toeq_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [63:0]                     in_tdata,
  input  wire logic [1:0]                      in_tuser,
  input  wire toeq_pkg::cmd_t                  cmd,
  output toeq_pkg::stat_t                      st,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [63:0]                          out_tdata,
  output logic [1:0]                           out_tuser
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]                            kind_r;
  logic signed [toeq_pkg::TIME_W-1:0]    key_r;
  logic [toeq_pkg::PAYLOAD_W-1:0]        pay_r;
  logic [AW-1:0]                         ptr_r, ptr_nxt;
  logic [CW-1:0]                         count_r, count_nxt;
  logic [1:0]                            res_status_r;
  logic signed [toeq_pkg::TIME_W-1:0]    res_time_r;
  logic [toeq_pkg::PAYLOAD_W-1:0]        res_pay_r;
  logic                                  out_valid_r;
  logic [1:0]                            out_status_r;
  logic [toeq_pkg::TIME_W-1:0]           out_time_r;
  logic [toeq_pkg::PAYLOAD_W-1:0]        out_pay_r;

  logic [CW-1:0]                         count_m1;
  logic [AW-1:0]                         ptr_p1;
  logic [toeq_pkg::ENTRY_W-1:0]          rdata;
  logic [toeq_pkg::ENTRY_W-1:0]          wdata;
  logic [AW-1:0]                         raddr, waddr;
  logic signed [toeq_pkg::TIME_W-1:0]    rd_time;

  assign count_m1 = count_r - CW'(1);
  assign ptr_p1   = ptr_r + AW'(1);
  assign rd_time  = $signed(rdata[toeq_pkg::TIME_W-1:0]);

  assign raddr = (cmd.rd_sel == toeq_pkg::ASEL_PTR_P1) ? ptr_p1 : ptr_r;
  assign waddr = (cmd.wr_sel == toeq_pkg::ASEL_PTR_P1) ? ptr_p1 : ptr_r;
  assign wdata = (cmd.wd_sel == toeq_pkg::WSEL_RDATA) ? rdata : {pay_r, key_r};

  // entry = {payload, time}
  toeq_ram #(
    .WIDTH (toeq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.ptr_op)
      toeq_pkg::PTR_ZERO: ptr_nxt = '0;
      toeq_pkg::PTR_TAIL: ptr_nxt = count_m1[AW-1:0];
      toeq_pkg::PTR_INC:  ptr_nxt = ptr_p1;
      toeq_pkg::PTR_DEC:  ptr_nxt = ptr_r - AW'(1);
      default:            ptr_nxt = ptr_r;
    endcase
    case (cmd.cnt_op)
      toeq_pkg::CNT_INC: count_nxt = count_r + CW'(1);
      toeq_pkg::CNT_DEC: count_nxt = count_m1;
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      kind_r       <= in_tuser;
      key_r        <= $signed(in_tdata[31:0]);
      pay_r        <= in_tdata[63:32];
      res_status_r <= toeq_pkg::ST_OK;
      res_time_r   <= '0;
      res_pay_r    <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (cmd.set_peek_empty) begin
        res_time_r <= toeq_pkg::INT_MIN;
      end
      if (cmd.cap_res || cmd.cap_peek) begin
        res_time_r <= rd_time;
      end
      if (cmd.cap_res) begin
        res_pay_r <= rdata[toeq_pkg::ENTRY_W-1:toeq_pkg::TIME_W];
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_time_r   <= res_time_r;
      out_pay_r    <= res_pay_r;
    end
  end

  always_comb begin
    st.kind     = kind_r;
    st.extreme  = (key_r == toeq_pkg::INT_MIN) || (key_r == toeq_pkg::INT_MAX);
    st.full     = (count_r == CW'(CAPACITY));
    st.empty    = (count_r == '0);
    st.ptr_zero = (ptr_r == '0);
    st.ptr_last = (CW'(ptr_r) == count_m1);
    st.rd_lt    = (rd_time < key_r);
    st.rd_eq    = (rd_time == key_r);
    st.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pay_r, out_time_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

@@ src/toeq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toeq_ctrl
// Sequencer for the event queue: decodes an item, walks the sorted store
// one entry at a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module toeq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire toeq_pkg::stat_t st,
  output toeq_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_EV  = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_SRCH_RD = 4'd5;
  localparam logic [3:0] S_SRCH_EV = 4'd6;
  localparam logic [3:0] S_PEEK_RD = 4'd7;
  localparam logic [3:0] S_PEEK_EV = 4'd8;
  localparam logic [3:0] S_SH_RD   = 4'd9;
  localparam logic [3:0] S_SH_EV   = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.kind)
          toeq_pkg::KIND_INSERT: begin
            if (st.extreme) begin
              cmd.set_status = 1'b1;
              cmd.status     = toeq_pkg::ST_IGNORED;
              state_nxt      = S_FIN;
            end else if (st.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = toeq_pkg::ST_FULL;
              state_nxt      = S_FIN;
            end else if (st.empty) begin
              cmd.ptr_op = toeq_pkg::PTR_ZERO;
              state_nxt  = S_INS_PUT;
            end else begin
              cmd.ptr_op = toeq_pkg::PTR_TAIL;
              state_nxt  = S_INS_RD;
            end
          end
          toeq_pkg::KIND_PEEK: begin
            if (st.empty) begin
              cmd.set_status     = 1'b1;
              cmd.status         = toeq_pkg::ST_EMPTY;
              cmd.set_peek_empty = 1'b1;
              state_nxt          = S_FIN;
            end else begin
              cmd.ptr_op = toeq_pkg::PTR_ZERO;
              state_nxt  = S_PEEK_RD;
            end
          end
          default: begin
            // dequeue and delete both scan from the head
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = toeq_pkg::ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              cmd.ptr_op = toeq_pkg::PTR_ZERO;
              state_nxt  = S_SRCH_RD;
            end
          end
        endcase
      end
      // insert: walk down from the tail, moving later-or-equal entries up
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = toeq_pkg::ASEL_PTR;
        state_nxt  = S_INS_EV;
      end
      S_INS_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = toeq_pkg::ASEL_PTR_P1;
        if (!st.rd_lt) begin
          cmd.wd_sel = toeq_pkg::WSEL_RDATA;
          if (st.ptr_zero) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.ptr_op = toeq_pkg::PTR_DEC;
            state_nxt  = S_INS_RD;
          end
        end else begin
          cmd.wd_sel = toeq_pkg::WSEL_NEW;
          cmd.cnt_op = toeq_pkg::CNT_INC;
          state_nxt  = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = toeq_pkg::ASEL_PTR;
        cmd.wd_sel = toeq_pkg::WSEL_NEW;
        cmd.cnt_op = toeq_pkg::CNT_INC;
        state_nxt  = S_FIN;
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = toeq_pkg::ASEL_PTR;
        state_nxt  = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if (st.kind == toeq_pkg::KIND_DEQUEUE || st.rd_eq) begin
          cmd.cap_res = 1'b1;
          state_nxt   = S_SH_RD;
        end else if (st.rd_lt && !st.ptr_last) begin
          cmd.ptr_op = toeq_pkg::PTR_INC;
          state_nxt  = S_SRCH_RD;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = toeq_pkg::ST_EMPTY;
          state_nxt      = S_FIN;
        end
      end
      S_PEEK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = toeq_pkg::ASEL_PTR;
        state_nxt  = S_PEEK_EV;
      end
      S_PEEK_EV: begin
        cmd.cap_peek = 1'b1;
        state_nxt    = S_FIN;
      end
      // removal: pull the entries behind the hole down by one
      S_SH_RD: begin
        if (st.ptr_last) begin
          cmd.cnt_op = toeq_pkg::CNT_DEC;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = toeq_pkg::ASEL_PTR_P1;
          state_nxt  = S_SH_EV;
        end
      end
      S_SH_EV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = toeq_pkg::ASEL_PTR;
        cmd.wd_sel = toeq_pkg::WSEL_RDATA;
        cmd.ptr_op = toeq_pkg::PTR_INC;
        state_nxt  = S_SH_RD;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
